// ----- rtl/hcqp_pkg.sv -----
// ----------------------------------------------------------------------------
// hcqp_pkg: shared types and constants of the message queue pool
// Slot entry layout, command and status codes, controller states and the
// widths that follow from the pool size and the ring depth.
// ----------------------------------------------------------------------------
package hcqp_pkg;

  localparam int QUEUE_SLOTS = 64;
  localparam int MAX_DEPTH   = 16;

  localparam int HANDLE_W = 31;
  localparam int IDX_W    = 12;
  localparam int GEN_W    = HANDLE_W - IDX_W;
  localparam int MSG_W    = 32;
  localparam int REQ_W    = 5;

  localparam int SLOT_W   = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
  localparam int DEPTH_W  = $clog2(MAX_DEPTH + 1);
  localparam int PTR_W    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int CNT_W    = DEPTH_W + 1;
  localparam int MSG_WORDS = QUEUE_SLOTS * MAX_DEPTH;
  localparam int MSG_AW   = (MSG_WORDS > 1) ? $clog2(MSG_WORDS) : 1;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 72;

  typedef enum logic [1:0] {
    CMD_CREATE  = 2'd0,
    CMD_DESTROY = 2'd1,
    CMD_SEND    = 2'd2,
    CMD_RECV    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_INVALID = 3'd1,
    ST_NO_SLOT = 3'd2,
    ST_FULL    = 3'd3,
    ST_EMPTY   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    HCQ_IDLE,
    HCQ_CHECK,
    HCQ_FETCH
  } hcq_state_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [DEPTH_W-1:0]  depth;
    logic [PTR_W-1:0]    rd_ptr;
    logic [DEPTH_W-1:0]  fill;
  } slot_entry_t;

  typedef struct packed {
    logic              wr_en;
    logic              set_busy;
    logic              clr_busy;
    logic [SLOT_W-1:0] idx;
    slot_entry_t       entry;
  } slot_wr_t;

endpackage

// ----- rtl/hcqp_slot_table.sv -----
// ----------------------------------------------------------------------------
// hcqp_slot_table: per-slot queue descriptors
// Synchronous descriptor memory with one registered read port and one write
// port, a busy bit per slot that reset clears, and a registered search for
// the lowest free slot.
// ----------------------------------------------------------------------------
module hcqp_slot_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [hcqp_pkg::SLOT_W-1:0]   rd_idx,
  output hcqp_pkg::slot_entry_t         rd_entry,
  output logic                          rd_busy,
  input  hcqp_pkg::slot_wr_t            wr,
  output logic [hcqp_pkg::SLOT_W-1:0]   free_idx,
  output logic                          free_any
);
  import hcqp_pkg::*;

  slot_entry_t              mem [QUEUE_SLOTS];
  slot_entry_t              rd_entry_r;
  logic                     rd_busy_r;
  logic [QUEUE_SLOTS-1:0]   busy_r, busy_nxt;
  logic [SLOT_W-1:0]        free_idx_r, free_idx_nxt;
  logic                     free_any_r, free_any_nxt;

  always_ff @(posedge clk) begin
    if (wr.wr_en) begin
      mem[wr.idx] <= wr.entry;
    end
    if (rd_en) begin
      rd_entry_r <= mem[rd_idx];
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    if (wr.set_busy) begin
      busy_nxt[wr.idx] = 1'b1;
    end
    if (wr.clr_busy) begin
      busy_nxt[wr.idx] = 1'b0;
    end
  end

  // lowest free slot wins: scan downward so the last hit is the lowest
  always_comb begin
    free_idx_nxt = '0;
    free_any_nxt = 1'b0;
    for (int i = QUEUE_SLOTS - 1; i >= 0; i--) begin
      if (!busy_r[i]) begin
        free_idx_nxt = SLOT_W'(i);
        free_any_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= '0;
      rd_busy_r  <= 1'b0;
      free_any_r <= 1'b0;
      free_idx_r <= '0;
    end else begin
      busy_r     <= busy_nxt;
      free_any_r <= free_any_nxt;
      free_idx_r <= free_idx_nxt;
      if (rd_en) begin
        rd_busy_r <= busy_r[rd_idx];
      end
    end
  end

  assign rd_entry = rd_entry_r;
  assign rd_busy  = rd_busy_r;
  assign free_idx = free_idx_r;
  assign free_any = free_any_r;

endmodule

// ----- rtl/hcqp_msg_ram.sv -----
// ----------------------------------------------------------------------------
// hcqp_msg_ram: message word store
// Single-port-write, single-port-read synchronous RAM holding every ring;
// slot s owns a contiguous block of MAX_DEPTH words.
// ----------------------------------------------------------------------------
module hcqp_msg_ram (
  input  logic                         clk,
  input  logic                         we,
  input  logic [hcqp_pkg::MSG_AW-1:0]  waddr,
  input  logic [hcqp_pkg::MSG_W-1:0]   wdata,
  input  logic                         re,
  input  logic [hcqp_pkg::MSG_AW-1:0]  raddr,
  output logic [hcqp_pkg::MSG_W-1:0]   rdata
);
  import hcqp_pkg::*;

  logic [MSG_W-1:0] mem [MSG_WORDS];
  logic [MSG_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/handle_checked_message_queue_pool_core.sv -----
// ----------------------------------------------------------------------------
// handle_checked_message_queue_pool_core: pool of handle-checked mailboxes
// Accepts create, destroy, send and receive commands and returns one status
// transaction per command, checking every non-create handle against its slot.
// ----------------------------------------------------------------------------
// One command is in work at a time. Create, destroy, send and a failed
// receive pass from acceptance to result through a descriptor read, then
// check and write-back; a successful receive adds a fetch step, as the
// message word is read from the ring store only once the descriptor gives
// its read pointer. A result waiting in the output register does not block
// the next command, but the command stalls at its final step until the
// register is free. Descriptor state lives in a 64-entry synchronous memory
// with busy bits cleared at reset, so no clearing pass is needed; message
// words live in a 1024-word RAM that is never cleared.
module handle_checked_message_queue_pool_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [30:0] queue_handle, [62:31] message_in, [67:63] depth_request, rest zero
  input  logic [hcqp_pkg::IN_DATA_W-1:0]      in_tdata,
  // [1:0] command
  input  logic [1:0]                          in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [2:0] status, [33:3] handle_out, [65:34] message_out, rest zero
  output logic [hcqp_pkg::OUT_DATA_W-1:0]     out_tdata
);
  import hcqp_pkg::*;

  hcq_state_t           state_r, state_nxt;
  cmd_t                 cmd_r;
  logic [HANDLE_W-1:0]  handle_r;
  logic [MSG_W-1:0]     msg_r;
  logic [REQ_W-1:0]     depth_r;
  logic [GEN_W-1:0]     gen_r, gen_nxt;

  logic                 out_valid_r;
  status_t              out_status_r;
  logic [HANDLE_W-1:0]  out_handle_r;
  logic [MSG_W-1:0]     out_msg_r;

  logic                 in_accept;
  logic                 out_free;

  slot_entry_t          rd_entry;
  logic                 rd_busy;
  logic [SLOT_W-1:0]    free_idx;
  logic                 free_any;
  slot_wr_t             slot_wr;

  logic                 msg_we, msg_re;
  logic [MSG_AW-1:0]    msg_waddr, msg_raddr;
  logic [MSG_W-1:0]     msg_rdata;

  logic [SLOT_W-1:0]    slot;
  logic                 idx_ok, hit, depth_bad;
  logic [CNT_W-1:0]     depth_ext, wsum, wpos, rnext;
  logic [MSG_AW-1:0]    base;

  logic                 res_load;
  status_t              res_status;
  logic [HANDLE_W-1:0]  res_handle;
  logic [MSG_W-1:0]     res_msg;
  logic                 commit, fetch;

  assign in_accept = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  hcqp_slot_table u_slot (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_accept),
    .rd_idx   (in_tdata[SLOT_W-1:0]),
    .rd_entry (rd_entry),
    .rd_busy  (rd_busy),
    .wr       (slot_wr),
    .free_idx (free_idx),
    .free_any (free_any)
  );

  hcqp_msg_ram u_msg (
    .clk   (clk),
    .we    (msg_we),
    .waddr (msg_waddr),
    .wdata (msg_r),
    .re    (msg_re),
    .raddr (msg_raddr),
    .rdata (msg_rdata)
  );

  // handle check and ring arithmetic on the descriptor just read
  assign slot      = handle_r[SLOT_W-1:0];
  assign idx_ok    = {1'b0, handle_r[IDX_W-1:0]} < (IDX_W + 1)'(QUEUE_SLOTS);
  assign hit       = idx_ok && rd_busy && (rd_entry.handle == handle_r);
  assign depth_bad = (depth_r == '0) || (32'(depth_r) > 32'(MAX_DEPTH));
  assign depth_ext = CNT_W'(rd_entry.depth);
  assign wsum      = CNT_W'(rd_entry.rd_ptr) + CNT_W'(rd_entry.fill);
  assign wpos      = (wsum >= depth_ext) ? (wsum - depth_ext) : wsum;
  assign rnext     = ((CNT_W'(rd_entry.rd_ptr) + CNT_W'(1)) >= depth_ext) ? '0
                   : (CNT_W'(rd_entry.rd_ptr) + CNT_W'(1));
  assign base      = MSG_AW'(slot) * MSG_AW'(MAX_DEPTH);

  always_comb begin
    state_nxt  = state_r;
    gen_nxt    = gen_r;
    in_tready  = 1'b0;
    slot_wr    = '0;
    slot_wr.idx = slot;
    slot_wr.entry = rd_entry;
    msg_we     = 1'b0;
    msg_re     = 1'b0;
    msg_waddr  = base + MSG_AW'(wpos[PTR_W-1:0]);
    msg_raddr  = base + MSG_AW'(rd_entry.rd_ptr);
    res_load   = 1'b0;
    res_status = ST_OK;
    res_handle = '0;
    res_msg    = '0;
    fetch      = 1'b0;
    commit     = 1'b0;
    case (state_r)
      HCQ_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = HCQ_CHECK;
        end
      end
      HCQ_CHECK: begin
        fetch  = (cmd_r == CMD_RECV) && hit && (rd_entry.fill != '0);
        commit = fetch || out_free;
        if (cmd_r == CMD_CREATE) begin
          if (depth_bad) begin
            res_status = ST_INVALID;
          end else if (!free_any) begin
            res_status = ST_NO_SLOT;
          end else begin
            res_handle             = {gen_r, IDX_W'(free_idx)};
            slot_wr.idx            = free_idx;
            slot_wr.entry.handle   = {gen_r, IDX_W'(free_idx)};
            slot_wr.entry.depth    = DEPTH_W'(depth_r);
            slot_wr.entry.rd_ptr   = '0;
            slot_wr.entry.fill     = '0;
            slot_wr.wr_en          = commit;
            slot_wr.set_busy       = commit;
            if (commit) begin
              gen_nxt = gen_r + GEN_W'(1);
            end
          end
        end else if (!hit) begin
          res_status = ST_INVALID;
        end else begin
          case (cmd_r)
            CMD_DESTROY: begin
              slot_wr.clr_busy = commit;
            end
            CMD_SEND: begin
              if (rd_entry.fill >= rd_entry.depth) begin
                res_status = ST_FULL;
              end else begin
                slot_wr.entry.fill = rd_entry.fill + DEPTH_W'(1);
                slot_wr.wr_en      = commit;
                msg_we             = commit;
              end
            end
            CMD_RECV: begin
              if (rd_entry.fill == '0) begin
                res_status = ST_EMPTY;
              end else begin
                slot_wr.entry.rd_ptr = rnext[PTR_W-1:0];
                slot_wr.entry.fill   = rd_entry.fill - DEPTH_W'(1);
                slot_wr.wr_en        = 1'b1;
                msg_re               = 1'b1;
              end
            end
            default: begin
              res_status = ST_INVALID;
            end
          endcase
        end
        if (fetch) begin
          state_nxt = HCQ_FETCH;
        end else if (out_free) begin
          res_load  = 1'b1;
          state_nxt = HCQ_IDLE;
        end
      end
      HCQ_FETCH: begin
        if (out_free) begin
          res_load  = 1'b1;
          res_msg   = msg_rdata;
          state_nxt = HCQ_IDLE;
        end
      end
      default: begin
        state_nxt = HCQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= HCQ_IDLE;
      gen_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      gen_r   <= gen_nxt;
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // hold the command fields for the whole transaction
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_r    <= cmd_t'(in_tuser);
      handle_r <= in_tdata[30:0];
      msg_r    <= in_tdata[62:31];
      depth_r  <= in_tdata[67:63];
    end
    if (res_load) begin
      out_status_r <= res_status;
      out_handle_r <= res_handle;
      out_msg_r    <= res_msg;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_msg_r, out_handle_r, out_status_r};

  a_fetch_follows_check: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == HCQ_FETCH |-> $past(state_r) == HCQ_CHECK || $past(state_r) == HCQ_FETCH)
    else $error("message fetch entered without a descriptor check");

  a_fields_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_OK |-> out_handle_r == '0 && out_msg_r == '0)
    else $error("result fields not zero on a refused command");

  a_no_accept_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> state_r == HCQ_CHECK && !in_tready)
    else $error("command accepted while another is in work");

  a_gen_steps_on_create: assert property (@(posedge clk) disable iff (!rst_n)
    gen_r != $past(gen_r) |-> $past(slot_wr.set_busy) && $past(cmd_r) == CMD_CREATE)
    else $error("generation counter moved without a successful create");

endmodule

// ----- dv/handle_checked_message_queue_pool_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// handle_checked_message_queue_pool_checker: result predictor and comparator
// Watches both stream channels of the queue pool, keeps a shadow copy of the
// slot table, the ring store and the generation count, and compares every
// result transaction field by field with the oldest predicted reply.
// ----------------------------------------------------------------------------
module handle_checked_message_queue_pool_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  // [30:0] queue_handle, [62:31] message_in, [67:63] depth_request, rest zero
  input  logic [hcqp_pkg::IN_DATA_W-1:0]  in_tdata,
  // [1:0] command
  input  logic [1:0]                      in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  // [2:0] status, [33:3] handle_out, [65:34] message_out, rest zero
  input  logic [hcqp_pkg::OUT_DATA_W-1:0] out_tdata,
  output int                              mismatch_count,
  output int                              pending_count
);
  import hcqp_pkg::*;

  typedef struct {
    status_t             status;
    logic [HANDLE_W-1:0] handle;
    logic [MSG_W-1:0]    message;
  } queue_reply_t;

  logic [HANDLE_W-1:0] shadow_handle [QUEUE_SLOTS];
  logic [DEPTH_W-1:0]  shadow_depth  [QUEUE_SLOTS];
  logic [PTR_W-1:0]    shadow_rd_ptr [QUEUE_SLOTS];
  logic [DEPTH_W-1:0]  shadow_fill   [QUEUE_SLOTS];
  logic [MSG_W-1:0]    shadow_ring   [MSG_WORDS];
  logic [GEN_W-1:0]    shadow_gen;

  queue_reply_t expected_replies[$];
  queue_reply_t want;
  int           mismatches;

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] exp_val);
    $display("[%0t] %s: got %h, expected %h", $time, field, got, exp_val);
    mismatches++;
  endtask

  // Apply one command to the shadow state and return the reply it produces.
  function automatic queue_reply_t apply_queue_command(cmd_t cmd, logic [HANDLE_W-1:0] hnd,
                                                       logic [MSG_W-1:0] word,
                                                       logic [REQ_W-1:0] depth);
    queue_reply_t r;
    int           free_slot;
    int           slot;
    int           ring_depth;
    int           pos;
    r.status  = ST_OK;
    r.handle  = '0;
    r.message = '0;
    free_slot = -1;
    slot      = int'(hnd[IDX_W-1:0]);
    if (cmd == CMD_CREATE) begin
      if (depth == 0 || depth > MAX_DEPTH) begin
        r.status = ST_INVALID;
      end else begin
        for (int i = QUEUE_SLOTS - 1; i >= 0; i--) begin
          if (shadow_depth[i] == 0) free_slot = i;
        end
        if (free_slot < 0) begin
          r.status = ST_NO_SLOT;
        end else begin
          r.handle = {shadow_gen, IDX_W'(free_slot)};
          shadow_gen++;
          shadow_handle[free_slot] = r.handle;
          shadow_depth[free_slot]  = DEPTH_W'(depth);
          shadow_rd_ptr[free_slot] = '0;
          shadow_fill[free_slot]   = '0;
        end
      end
    end else if (slot >= QUEUE_SLOTS) begin
      r.status = ST_INVALID;
    end else if (shadow_depth[slot] == 0 || shadow_handle[slot] != hnd) begin
      r.status = ST_INVALID;
    end else begin
      ring_depth = int'(shadow_depth[slot]);
      case (cmd)
        CMD_DESTROY: begin
          shadow_depth[slot]  = '0;
          shadow_handle[slot] = '0;
        end
        CMD_SEND: begin
          if (shadow_fill[slot] >= ring_depth) begin
            r.status = ST_FULL;
          end else begin
            pos = int'(shadow_rd_ptr[slot]) + int'(shadow_fill[slot]);
            if (pos >= ring_depth) pos -= ring_depth;
            shadow_ring[slot * MAX_DEPTH + pos] = word;
            shadow_fill[slot]++;
          end
        end
        default: begin
          if (shadow_fill[slot] == 0) begin
            r.status = ST_EMPTY;
          end else begin
            pos       = int'(shadow_rd_ptr[slot]);
            r.message = shadow_ring[slot * MAX_DEPTH + pos];
            pos++;
            if (pos >= ring_depth) pos -= ring_depth;
            shadow_rd_ptr[slot] = PTR_W'(pos);
            shadow_fill[slot]--;
          end
        end
      endcase
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < QUEUE_SLOTS; i++) begin
        shadow_handle[i] = '0;
        shadow_depth[i]  = '0;
        shadow_rd_ptr[i] = '0;
        shadow_fill[i]   = '0;
      end
      shadow_gen = '0;
      expected_replies.delete();
      mismatches = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_replies.size() == 0) begin
          report_mismatch("result with no command pending", out_tdata[31:0], '0);
        end else begin
          want = expected_replies.pop_front();
          if (out_tdata[2:0] !== want.status)
            report_mismatch("status", 32'(out_tdata[2:0]), 32'(want.status));
          if (out_tdata[33:3] !== want.handle)
            report_mismatch("handle_out", 32'(out_tdata[33:3]), 32'(want.handle));
          if (out_tdata[65:34] !== want.message)
            report_mismatch("message_out", out_tdata[65:34], want.message);
          if (out_tdata[OUT_DATA_W-1:66] !== '0)
            report_mismatch("padding", 32'(out_tdata[OUT_DATA_W-1:66]), '0);
        end
      end
      if (in_tvalid && in_tready) begin
        expected_replies.insert(expected_replies.size(),
                                apply_queue_command(cmd_t'(in_tuser), in_tdata[30:0],
                                                    in_tdata[62:31], in_tdata[67:63]));
      end
    end
    // publish after the edge so readers in the same step see settled counts
    mismatch_count <= mismatches;
    pending_count  <= expected_replies.size();
  end

endmodule

// ----- dv/handle_checked_message_queue_pool_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// handle_checked_message_queue_pool_core_tb: queue pool stream testbench
// Drives a directed run through every command and corner of the handle
// check, then phases of random traffic that fill, drain and exercise the
// rings, with random idling on both channels; the checker grades results.
// ----------------------------------------------------------------------------
module handle_checked_message_queue_pool_core_tb;
  import hcqp_pkg::*;

  localparam int RANDOM_ITEMS = 900;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 8;

  typedef enum int {
    MODE_FILL,
    MODE_DRAIN,
    MODE_TRAFFIC,
    MODE_NOISE
  } traffic_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [1:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  int                    mismatch_count;
  int                    pending_count;

  logic [HANDLE_W-1:0] live_handles[$];
  logic [HANDLE_W-1:0] retired_handles[$];
  cmd_t                issued_cmds[$];
  cmd_t                done_cmd;
  bit                  tx_steady = 1'b0;
  bit                  rx_steady = 1'b0;
  int                  idle_cycles;

  handle_checked_message_queue_pool_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  handle_checked_message_queue_pool_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [HANDLE_W-1:0] pick_handle(int live_pct);
    logic [HANDLE_W-1:0] h;
    if (live_handles.size() != 0 && $urandom_range(0, 99) < live_pct)
      return live_handles[$urandom_range(0, live_handles.size() - 1)];
    case ($urandom_range(0, 3))
      0: h = HANDLE_W'($urandom);
      1: h = (live_handles.size() != 0) ?
             live_handles[0] ^ (31'd1 << $urandom_range(IDX_W, HANDLE_W - 1)) :
             HANDLE_W'($urandom);
      2: h = (retired_handles.size() != 0) ?
             retired_handles[$urandom_range(0, retired_handles.size() - 1)] :
             HANDLE_W'($urandom);
      default: h = {GEN_W'($urandom), IDX_W'($urandom_range(0, QUEUE_SLOTS - 1))};
    endcase
    return h;
  endfunction

  function automatic logic [MSG_W-1:0] pick_word();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    return $urandom;
  endfunction

  function automatic logic [REQ_W-1:0] pick_depth();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 14) return REQ_W'($urandom_range(MAX_DEPTH + 1, 31));
    if (r < 60) return REQ_W'($urandom_range(1, 3));
    return REQ_W'($urandom_range(1, MAX_DEPTH));
  endfunction

  // Present one command and hold it until the block takes it.
  task automatic send_command(cmd_t cmd, logic [HANDLE_W-1:0] hnd, logic [MSG_W-1:0] word,
                              logic [REQ_W-1:0] depth);
    int gap;
    int found;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= IN_DATA_W'({depth, word, hnd});
    do @(posedge clk); while (!in_tready);
    if (cmd == CMD_DESTROY) begin
      found = -1;
      for (int i = 0; i < live_handles.size(); i++) begin
        if (found < 0 && live_handles[i] == hnd) found = i;
      end
      if (found >= 0) begin
        live_handles.delete(found);
        retired_handles.insert(retired_handles.size(), hnd);
        if (retired_handles.size() > 16) void'(retired_handles.pop_front());
      end
    end
  endtask

  task automatic random_item(traffic_mode_t mode);
    int                  pick;
    int                  create_w;
    int                  destroy_w;
    int                  send_w;
    cmd_t                cmd;
    case (mode)
      MODE_FILL:    begin create_w = 70; destroy_w = 5;  send_w = 15; end
      MODE_DRAIN:   begin create_w = 5;  destroy_w = 50; send_w = 20; end
      MODE_TRAFFIC: begin create_w = 8;  destroy_w = 7;  send_w = 45; end
      default:      begin create_w = 25; destroy_w = 25; send_w = 25; end
    endcase
    pick = $urandom_range(0, 99);
    if (pick < create_w) cmd = CMD_CREATE;
    else if (pick < create_w + destroy_w) cmd = CMD_DESTROY;
    else if (pick < create_w + destroy_w + send_w) cmd = CMD_SEND;
    else cmd = CMD_RECV;
    if (mode != MODE_NOISE && live_handles.size() == 0 && $urandom_range(0, 3) != 0)
      cmd = CMD_CREATE;
    send_command(cmd, pick_handle((mode == MODE_NOISE) ? 30 : 90), pick_word(),
                 pick_depth());
  endtask

  // Learn new handles from successful create results.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready && issued_cmds.size() != 0) begin
        done_cmd = issued_cmds.pop_front();
        if (done_cmd == CMD_CREATE && out_tdata[2:0] == ST_OK)
          live_handles.insert(live_handles.size(), out_tdata[33:3]);
      end
      if (in_tvalid && in_tready) issued_cmds.insert(issued_cmds.size(), cmd_t'(in_tuser));
    end
  end

  // Result side: random ready pattern with steady stretches.
  initial begin
    int run_len;
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 49) == 0) rx_steady = !rx_steady;
      run_len = $urandom_range(1, 8);
      out_tready <= 1'b1;
      repeat (run_len) @(posedge clk);
      gap = rx_steady ? 0 : pick_gap();
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long.
  initial begin
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    traffic_mode_t mode;
    int            phase_left;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: depth limits, full and empty rings, stale and foreign handles.
    send_command(CMD_CREATE,  31'h0,         32'h0,         5'd0);
    send_command(CMD_CREATE,  31'h7FFF_FFFF, 32'hFFFF_FFFF, 5'd17);
    send_command(CMD_CREATE,  31'h0,         32'h0,         5'd31);
    send_command(CMD_CREATE,  31'h0,         32'h0,         5'd1);
    send_command(CMD_CREATE,  31'h0,         32'h0,         5'd16);
    send_command(CMD_RECV,    31'h0,         32'h0,         5'd0);
    send_command(CMD_SEND,    31'h0,         32'h0,         5'd0);
    send_command(CMD_SEND,    31'h0,         32'hFFFF_FFFF, 5'd0);
    send_command(CMD_RECV,    31'h0,         32'h0,         5'd0);
    send_command(CMD_SEND,    31'h0000_1001, 32'hFFFF_FFFF, 5'd0);
    send_command(CMD_SEND,    31'h0000_1001, 32'hA5A5_A5A5, 5'd0);
    send_command(CMD_RECV,    31'h0000_1001, 32'h0,         5'd0);
    send_command(CMD_DESTROY, 31'h4000_1001, 32'h0,         5'd0);
    send_command(CMD_DESTROY, 31'h0,         32'h0,         5'd0);
    send_command(CMD_SEND,    31'h0,         32'h1234_5678, 5'd0);
    send_command(CMD_RECV,    31'h7FFF_FFFF, 32'h0,         5'd0);
    send_command(CMD_DESTROY, 31'h0000_003F, 32'h0,         5'd0);
    send_command(CMD_CREATE,  31'h0,         32'h0,         5'd16);
    send_command(CMD_SEND,    31'h0000_2000, 32'h1234_5678, 5'd0);
    send_command(CMD_RECV,    31'h0000_2000, 32'h0,         5'd0);
    send_command(CMD_DESTROY, 31'h0000_1001, 32'h0,         5'd0);
    send_command(CMD_DESTROY, 31'h0000_2000, 32'h0,         5'd0);

    // Random phases; open with a fill long enough to exhaust the pool.
    mode       = MODE_FILL;
    phase_left = 160;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        mode       = traffic_mode_t'($urandom_range(0, 3));
        phase_left = $urandom_range(60, 150);
        tx_steady  = ($urandom_range(0, 3) == 0);
      end
      random_item(mode);
      phase_left--;
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/hcqp_pkg.sv
rtl/hcqp_slot_table.sv
rtl/hcqp_msg_ram.sv
rtl/handle_checked_message_queue_pool_core.sv
dv/handle_checked_message_queue_pool_checker.sv
dv/handle_checked_message_queue_pool_core_tb.sv
